[rtl/copscan_pkg.sv]
// ----------------------------------------------------------------------------
// CoAP option scan package
// Shared types, codes and constants of the CoAP option presence scanner.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package copscan_pkg;

  // Longest token that the header may announce.
  localparam int unsigned MAX_TOKEN_LEN = 8;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned VERDICT_W = 3;
  localparam int unsigned OPTNUM_W  = 16;
  localparam int unsigned EXT_W     = 17;
  localparam int unsigned VERSION_W = 2;

  // Fixed CoAP header length in bytes.
  localparam logic [2:0] HEADER_LEN = 3'd4;

  localparam logic [BYTE_W-1:0] PAYLOAD_MARKER = 8'hFF;
  localparam logic [3:0]        NIB_EXT1       = 4'd13;
  localparam logic [3:0]        NIB_EXT2       = 4'd14;
  localparam logic [3:0]        NIB_RESERVED   = 4'd15;
  localparam logic [EXT_W-1:0]  EXT1_BIAS      = 17'd13;
  localparam logic [EXT_W-1:0]  EXT2_BIAS      = 17'd269;

  // APB register map: register index sits at paddr[2].
  localparam int unsigned APB_ADDR_W = 3;
  localparam int unsigned APB_DATA_W = 32;
  localparam logic        REG_TARGET_OPTION    = 1'b0;
  localparam logic        REG_EXPECTED_VERSION = 1'b1;

  localparam logic [OPTNUM_W-1:0]  TARGET_OPTION_RST    = 16'd9;
  localparam logic [VERSION_W-1:0] EXPECTED_VERSION_RST = 2'd1;

  typedef enum logic [VERDICT_W-1:0] {
    V_FOUND  = 3'd0,
    V_PASSED = 3'd1,
    V_CLEAN  = 3'd2,
    V_BADHDR = 3'd3,
    V_BADOPT = 3'd4
  } verdict_e;

  typedef enum logic [9:0] {
    PH_HDR   = 10'b00_0000_0001,
    PH_TOKEN = 10'b00_0000_0010,
    PH_OPT   = 10'b00_0000_0100,
    PH_D1    = 10'b00_0000_1000,
    PH_D2A   = 10'b00_0001_0000,
    PH_D2B   = 10'b00_0010_0000,
    PH_L1    = 10'b00_0100_0000,
    PH_L2A   = 10'b00_1000_0000,
    PH_L2B   = 10'b01_0000_0000,
    PH_SKIP  = 10'b10_0000_0000
  } phase_e;

endpackage

[rtl/copscan_if.sv]
// ----------------------------------------------------------------------------
// CoAP option scan channels
// Valid/ready channels for message bytes and for scan results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface copscan_byte_if;
  import copscan_pkg::*;

  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] data_byte;
  logic              last;

  modport source (output valid, output data_byte, output last, input ready);
  modport sink   (input valid, input data_byte, input last, output ready);
endinterface

interface copscan_result_if;
  import copscan_pkg::*;

  logic                 valid;
  logic                 ready;
  logic                 option_found;
  logic [VERDICT_W-1:0] verdict;

  modport source (output valid, output option_found, output verdict, input ready);
  modport sink   (input valid, input option_found, input verdict, output ready);
endinterface

[rtl/coap_option_presence_scan_unit.sv]
// ----------------------------------------------------------------------------
// CoAP option presence scan unit
// A byte marked last passes through the input register and then the result
//   register, and waits in the input register while an earlier result stalls.
// Throughput: one byte per cycle while no last byte is held back by a stalled
//   result; the parser state updates in a single pass of short logic, at most
//   an extension add feeding the 16-bit option number add and compare.
// Reset: rst_ni clears the scan state, both channels and the registers
//   (target option 9, expected version 1).
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module coap_option_presence_scan_unit (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  copscan_byte_if.sink                         req_i,
  copscan_result_if.source                     res_o,
  input  logic                                 psel,
  input  logic                                 penable,
  input  logic                                 pwrite,
  input  logic [copscan_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [copscan_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [copscan_pkg::APB_DATA_W-1:0]   prdata,
  output logic                                 pready
);
  import copscan_pkg::*;

  // Configuration registers. A write lands on the access cycle; the index
  // is taken from paddr[2] and the low address bits are ignored.
  logic [OPTNUM_W-1:0]  target_q;
  logic [VERSION_W-1:0] version_q;
  logic                 cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= TARGET_OPTION_RST;
      version_q <= EXPECTED_VERSION_RST;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_TARGET_OPTION) begin
        target_q <= pwdata[OPTNUM_W-1:0];
      end else begin
        version_q <= pwdata[VERSION_W-1:0];
      end
    end
  end

  always_comb begin
    if (paddr[2] == REG_EXPECTED_VERSION) begin
      prdata = {{(APB_DATA_W-VERSION_W){1'b0}}, version_q};
    end else begin
      prdata = {{(APB_DATA_W-OPTNUM_W){1'b0}}, target_q};
    end
  end

  // Input register. A request waits here for one pass of the parser. It
  // moves on unless it is the last byte and the result register is still
  // full and stalled, so bytes stream at full rate while a result waits.
  logic              in_valid_q;
  logic [BYTE_W-1:0] byte_q;
  logic              last_q;
  logic              out_valid_q;
  logic              proc_fire;

  assign proc_fire   = in_valid_q && (!last_q || !out_valid_q || res_o.ready);
  assign req_i.ready = !in_valid_q || proc_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (req_i.ready) begin
      in_valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_i.valid && req_i.ready) begin
      byte_q <= req_i.data_byte;
      last_q <= req_i.last;
    end
  end

  // Parser state.
  phase_e              phase_q, phase_d;
  logic [2:0]          hdr_cnt_q, hdr_cnt_d;
  logic [3:0]          token_q, token_d;
  logic [OPTNUM_W-1:0] optnum_q, optnum_d;
  logic [EXT_W-1:0]    pdelta_q, pdelta_d;
  logic [EXT_W-1:0]    plen_q, plen_d;
  logic [EXT_W-1:0]    skip_q, skip_d;
  logic                decided_q, decided_d;
  verdict_e            held_q, held_d;

  // Per-byte work variables.
  logic                do_after;
  logic                do_finish;
  logic [OPTNUM_W-1:0] opt_sum;
  logic [3:0]          nib_d;
  logic [3:0]          nib_l;
  verdict_e            verdict_d;

  assign nib_d = byte_q[7:4];
  assign nib_l = byte_q[3:0];

  always_comb begin
    phase_d   = phase_q;
    hdr_cnt_d = hdr_cnt_q;
    token_d   = token_q;
    optnum_d  = optnum_q;
    pdelta_d  = pdelta_q;
    plen_d    = plen_q;
    skip_d    = skip_q;
    decided_d = decided_q;
    held_d    = held_q;
    do_after  = 1'b0;
    do_finish = 1'b0;
    opt_sum   = optnum_q + pdelta_q[OPTNUM_W-1:0];

    // Once a verdict is held, later bytes of the message are ignored.
    if (!decided_q) begin
      unique case (phase_q)
        PH_HDR: begin
          if (hdr_cnt_q == 3'd0 && byte_q[7:6] != version_q) begin
            decided_d = 1'b1;
            held_d    = V_BADHDR;
          end else if (hdr_cnt_q == 3'd0 && nib_l > 4'(MAX_TOKEN_LEN)) begin
            decided_d = 1'b1;
            held_d    = V_BADHDR;
          end else begin
            if (hdr_cnt_q == 3'd0) begin
              token_d = nib_l;
            end
            hdr_cnt_d = hdr_cnt_q + 3'd1;
            if (hdr_cnt_d >= HEADER_LEN) begin
              phase_d = (token_d != 4'd0) ? PH_TOKEN : PH_OPT;
            end
          end
        end
        PH_TOKEN: begin
          token_d = token_q - 4'd1;
          if (token_d == 4'd0) begin
            phase_d = PH_OPT;
          end
        end
        PH_OPT: begin
          if (byte_q == PAYLOAD_MARKER) begin
            decided_d = 1'b1;
            held_d    = V_CLEAN;
          end else if (nib_d == NIB_RESERVED || nib_l == NIB_RESERVED) begin
            decided_d = 1'b1;
            held_d    = V_BADOPT;
          end else begin
            pdelta_d = {13'd0, nib_d};
            plen_d   = {13'd0, nib_l};
            if (nib_d == NIB_EXT1) begin
              phase_d = PH_D1;
            end else if (nib_d == NIB_EXT2) begin
              phase_d = PH_D2A;
            end else begin
              do_after = 1'b1;
            end
          end
        end
        PH_D1: begin
          pdelta_d = {9'd0, byte_q} + EXT1_BIAS;
          do_after = 1'b1;
        end
        PH_D2A: begin
          pdelta_d = {1'b0, byte_q, 8'h00};
          phase_d  = PH_D2B;
        end
        PH_D2B: begin
          pdelta_d = {1'b0, pdelta_q[15:8], byte_q} + EXT2_BIAS;
          do_after = 1'b1;
        end
        PH_L1: begin
          plen_d    = {9'd0, byte_q} + EXT1_BIAS;
          do_finish = 1'b1;
        end
        PH_L2A: begin
          plen_d  = {1'b0, byte_q, 8'h00};
          phase_d = PH_L2B;
        end
        PH_L2B: begin
          plen_d    = {1'b0, plen_q[15:8], byte_q} + EXT2_BIAS;
          do_finish = 1'b1;
        end
        PH_SKIP: begin
          skip_d = skip_q - 17'd1;
          if (skip_d == 17'd0) begin
            phase_d = PH_OPT;
          end
        end
        default: begin
          phase_d = PH_OPT;
        end
      endcase
    end

    // With the delta settled, a length nibble of 13 or 14 still needs its
    // extension bytes; otherwise the option header is complete.
    if (do_after) begin
      if (plen_d == {13'd0, NIB_EXT1}) begin
        phase_d = PH_L1;
      end else if (plen_d == {13'd0, NIB_EXT2}) begin
        phase_d = PH_L2A;
      end else begin
        do_finish = 1'b1;
      end
    end

    // Complete option header: advance the wrapping option number and
    // compare it with the target.
    if (do_finish) begin
      opt_sum  = optnum_q + pdelta_d[OPTNUM_W-1:0];
      optnum_d = opt_sum;
      if (opt_sum == target_q) begin
        decided_d = 1'b1;
        held_d    = V_FOUND;
      end else if (opt_sum > target_q) begin
        decided_d = 1'b1;
        held_d    = V_PASSED;
      end else begin
        skip_d  = plen_d;
        phase_d = (plen_d != 17'd0) ? PH_SKIP : PH_OPT;
      end
    end

    // Verdict for a message that ends on this byte. A held verdict is kept;
    // otherwise an end inside the header is a bad header, an end inside an
    // extension is malformed, and any other end is clean.
    if (decided_d) begin
      verdict_d = held_d;
    end else if (phase_d == PH_HDR) begin
      verdict_d = V_BADHDR;
    end else if (phase_d == PH_D1 || phase_d == PH_D2A || phase_d == PH_D2B ||
                 phase_d == PH_L1 || phase_d == PH_L2A || phase_d == PH_L2B) begin
      verdict_d = V_BADOPT;
    end else begin
      verdict_d = V_CLEAN;
    end

    // The last byte returns the scan to its starting state.
    if (last_q) begin
      phase_d   = PH_HDR;
      hdr_cnt_d = 3'd0;
      token_d   = 4'd0;
      optnum_d  = '0;
      pdelta_d  = '0;
      plen_d    = '0;
      skip_d    = '0;
      decided_d = 1'b0;
      held_d    = V_CLEAN;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_HDR;
      hdr_cnt_q <= 3'd0;
      token_q   <= 4'd0;
      optnum_q  <= '0;
      pdelta_q  <= '0;
      plen_q    <= '0;
      skip_q    <= '0;
      decided_q <= 1'b0;
      held_q    <= V_CLEAN;
    end else if (proc_fire) begin
      phase_q   <= phase_d;
      hdr_cnt_q <= hdr_cnt_d;
      token_q   <= token_d;
      optnum_q  <= optnum_d;
      pdelta_q  <= pdelta_d;
      plen_q    <= plen_d;
      skip_q    <= skip_d;
      decided_q <= decided_d;
      held_q    <= held_d;
    end
  end

  // Result register.
  verdict_e verdict_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (proc_fire && last_q) begin
      out_valid_q <= 1'b1;
    end else if (res_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (proc_fire && last_q) begin
      verdict_q <= verdict_d;
    end
  end

  assign res_o.valid        = out_valid_q;
  assign res_o.verdict      = verdict_q;
  assign res_o.option_found = (verdict_q == V_FOUND);

  // A last byte that passes the parser always leaves a result behind.
  a_last_gives_result: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (proc_fire && last_q) |=> out_valid_q
  ) else $error("last byte processed without a result");

  // A held verdict freezes the walk until the message ends.
  a_decided_freezes: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (proc_fire && decided_q && !last_q) |=> ($stable(phase_q) && $stable(optnum_q))
  ) else $error("parser state moved after a verdict was held");

  // The header counter never runs past the header while in the header phase.
  a_hdr_count: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (phase_q == PH_HDR) |-> (hdr_cnt_q < HEADER_LEN)
  ) else $error("header counter overran the header");

  // The token count was checked against its limit when it was loaded.
  a_token_bound: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    token_q <= 4'(MAX_TOKEN_LEN)
  ) else $error("token count exceeds the token length limit");

endmodule
